FILE: hw/rtl/tshw_pkg.sv
// Shared types, widths and codes of the hot-water demand block.
package tshw_pkg;

   localparam int TEMP_W  = 7;
   localparam int LAYER_W = 44;   // signed Q28.16 store and layer values
   localparam int PROD_W  = 61;   // product of LAYER_W by 17 signed bits
   localparam int SHARE_W = 32;   // signed Q16.16 share
   localparam int FAC_W   = 27;   // signed Q.8 draw factor
   localparam int DIV_NW  = 60;   // signed dividend and quotient
   localparam int DIV_DW  = 26;   // signed divisor
   localparam int CNT_W   = 6;    // holds DIV_NW

   localparam int MIN_FLOW_DEF   = 30;
   localparam int HYSTERESIS_DEF = 5;
   localparam logic [TEMP_W-1:0] OFF_TARGET = 7'd30;

   localparam logic [1:0] MODE_OFF = 2'd0;
   localparam logic [1:0] MODE_ON  = 2'd1;

   localparam logic [2:0] REG_BOTTOM_CAP = 3'd0;
   localparam logic [2:0] REG_MIDDLE_CAP = 3'd1;
   localparam logic [2:0] REG_UPPER_CAP  = 3'd2;
   localparam logic [2:0] REG_BOTTOM_VOL = 3'd3;
   localparam logic [2:0] REG_MIDDLE_VOL = 3'd4;
   localparam logic [2:0] REG_UPPER_VOL  = 3'd5;
   localparam logic [2:0] REG_DRAW_GAIN  = 3'd6;
   localparam logic [2:0] REG_BOILER     = 3'd7;

   typedef struct packed {
      logic [15:0] bottom_capacity;
      logic [15:0] middle_capacity;
      logic [15:0] upper_capacity;
      logic [15:0] bottom_volume;
      logic [15:0] middle_volume;
      logic [15:0] upper_volume;
      logic [15:0] draw_gain;
      logic [23:0] boiler_energy;
   } cfg_type;

   typedef struct packed {
      logic [TEMP_W-1:0] call_temp;
      logic [TEMP_W-1:0] next_temp;
      logic [TEMP_W-1:0] top_temp;
      logic [TEMP_W-1:0] mid_temp;
      logic [TEMP_W-1:0] bottom_temp;
      logic [1:0]        mode;
      logic              was_heating;
      logic              back_boiler_on;
   } item_type;

   typedef struct packed {
      logic       idle;
      logic       done;
      logic [7:0] delivery_temp;
      logic       need_heat;
   } core_status_type;

endpackage

FILE: hw/rtl/tshw_div.sv
// Bit-serial signed divider, quotient truncated toward zero.
module tshw_div import tshw_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DIV_NW-1:0] dividend,
   input  logic signed [DIV_DW-1:0] divisor,
   output logic                     done,
   output logic signed [DIV_NW-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_NW-1:0] q_ff, q_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] dmag_ff, dmag_in;
   logic              neg_ff, neg_in;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   shifted;

   assign shifted = {rem_ff, q_ff[DIV_NW-1]};
   assign trial   = shifted - {1'b0, dmag_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NW);
         q_in    = dividend[DIV_NW-1] ? DIV_NW'(-dividend) : DIV_NW'(dividend);
         rem_in  = '0;
         dmag_in = divisor[DIV_DW-1] ? DIV_DW'(-divisor) : DIV_DW'(divisor);
         neg_in  = dividend[DIV_NW-1] ^ divisor[DIV_DW-1];
      end else if (busy_ff) begin
         if (!trial[DIV_DW]) begin
            rem_in = trial[DIV_DW-1:0];
            q_in   = {q_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_DW-1:0];
            q_in   = {q_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -signed'(q_ff) : signed'(q_ff);

endmodule

FILE: hw/rtl/tshw_core.sv
// Sequencer and datapath of the store model around one multiplier and one divider.
module tshw_core import tshw_pkg::*; #(
   parameter int MIN_FLOW   = MIN_FLOW_DEF,
   parameter int HYSTERESIS = HYSTERESIS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  item_type        item,
   input  logic [7:0]      ground,
   input  cfg_type         cfg,
   input  logic            ack,
   output core_status_type status
);

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_LMUL  = 14'b00000000000010,
      S_LACC  = 14'b00000000000100,
      S_DCHK  = 14'b00000000001000,
      S_DGO   = 14'b00000000010000,
      S_DWAIT = 14'b00000000100000,
      S_FMUL  = 14'b00000001000000,
      S_FACC  = 14'b00000010000000,
      S_PLO   = 14'b00000100000000,
      S_PHI   = 14'b00001000000000,
      S_PSUM  = 14'b00010000000000,
      S_VGO   = 14'b00100000000000,
      S_VWAIT = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   localparam logic signed [DIV_NW-1:0] SHARE_MAX = DIV_NW'(64'sh7FFFFFFF);
   localparam logic signed [DIV_NW-1:0] SHARE_MIN = -DIV_NW'(64'sh80000000);
   localparam logic signed [DIV_NW:0]   STORE_LIM = (DIV_NW+1)'(64'sh10000000000);

   state_type state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic       pass_ff, pass_in;
   item_type   item_ff, item_in;
   logic [7:0] g_ff, g_in;
   logic signed [LAYER_W-1:0] h0_ff, h1_ff, h2_ff, h0_in, h1_in, h2_in;
   logic signed [LAYER_W-1:0] st0_ff, st1_ff, st2_ff, st0_in, st1_in, st2_in;
   logic signed [SHARE_W-1:0] sh0_ff, sh1_ff, sh2_ff, sh0_in, sh1_in, sh2_in;
   logic signed [FAC_W-1:0]   fac_ff, fac_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [DIV_NW-1:0]  acc_ff, acc_in;

   logic signed [LAYER_W-1:0] g_ext, src, prev, reading, den, new_h, new_st;
   logic signed [LAYER_W-1:0] mul_a;
   logic signed [16:0]        mul_b;
   logic [15:0]               cap, vol;
   logic signed [SHARE_W-1:0] sh_sel, new_sh;
   logic [TEMP_W-1:0]         req, target;
   logic signed [8:0]         rise;
   logic                      div_start, div_done;
   logic signed [DIV_NW-1:0]  div_n, quotient, drop;
   logic signed [DIV_DW-1:0]  div_d;
   logic signed [DIV_NW:0]    st_diff;
   logic signed [LAYER_W:0]   v;
   logic [7:0]                delivery;
   logic [8:0]                limit;
   logic                      hyst_on;

   assign g_ext = signed'({{(LAYER_W-24){1'b0}}, g_ff, 16'b0});
   assign req   = (item_ff.next_temp > item_ff.call_temp) ? item_ff.next_temp
                                                          : item_ff.call_temp;
   assign rise  = signed'({2'b0, req}) - signed'({1'b0, g_ff});

   always_comb begin
      case (k_ff)
         2'd0: begin
            reading = signed'({{(LAYER_W-23){1'b0}}, item_ff.bottom_temp, 16'b0});
            prev    = g_ext;
            cap     = cfg.bottom_capacity;
            vol     = cfg.bottom_volume;
            sh_sel  = sh0_ff;
            src     = pass_ff ? st0_ff : reading;
            new_h   = h0_ff;
         end
         2'd1: begin
            reading = signed'({{(LAYER_W-23){1'b0}}, item_ff.mid_temp, 16'b0});
            prev    = h0_ff;
            cap     = cfg.middle_capacity;
            vol     = cfg.middle_volume;
            sh_sel  = sh1_ff;
            src     = pass_ff ? st1_ff : reading;
            new_h   = h1_ff;
         end
         default: begin
            reading = signed'({{(LAYER_W-23){1'b0}}, item_ff.top_temp, 16'b0});
            prev    = h1_ff;
            cap     = cfg.upper_capacity;
            vol     = cfg.upper_volume;
            sh_sel  = sh2_ff;
            src     = pass_ff ? st2_ff : reading;
            new_h   = h2_ff;
         end
      endcase
   end

   // The shared multiplier; its product is always registered.
   always_comb begin
      mul_a = src - prev;
      mul_b = signed'({1'b0, cap});
      if (state_ff == S_FMUL) begin
         mul_a = LAYER_W'(rise);
         mul_b = signed'({1'b0, cfg.draw_gain});
      end else if (state_ff == S_PLO) begin
         mul_a = LAYER_W'(fac_ff);
         mul_b = signed'({1'b0, sh_sel[15:0]});
      end else if (state_ff == S_PHI) begin
         mul_a = LAYER_W'(fac_ff);
         mul_b = signed'({sh_sel[31], sh_sel[31:16]});
      end
      prod_in = PROD_W'(mul_a * mul_b);
   end

   assign den = h2_ff - g_ext;

   always_comb begin
      div_n = acc_ff;
      div_d = signed'({{(DIV_DW-16){1'b0}}, vol});
      if (state_ff == S_DGO) begin
         div_n = DIV_NW'(new_h - prev) <<< 16;
         div_d = DIV_DW'(den);
      end
   end

   assign div_start = (state_ff == S_DGO) || ((state_ff == S_VGO) && (vol != 16'd0));
   assign drop      = (state_ff == S_VGO) ? '0 : quotient;
   assign st_diff   = (DIV_NW+1)'(reading) - (DIV_NW+1)'(drop);
   assign new_st    = (st_diff > STORE_LIM) ? LAYER_W'(STORE_LIM) :
                      (st_diff < -STORE_LIM) ? LAYER_W'(-STORE_LIM) : LAYER_W'(st_diff);
   assign new_sh    = (quotient > SHARE_MAX) ? SHARE_W'(SHARE_MAX) :
                      (quotient < SHARE_MIN) ? SHARE_W'(SHARE_MIN) : SHARE_W'(quotient);

   tshw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      pass_in  = pass_ff;
      item_in  = item_ff;
      g_in     = g_ff;
      h0_in = h0_ff; h1_in = h1_ff; h2_in = h2_ff;
      st0_in = st0_ff; st1_in = st1_ff; st2_in = st2_ff;
      sh0_in = sh0_ff; sh1_in = sh1_ff; sh2_in = sh2_ff;
      fac_in = fac_ff;
      acc_in = acc_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in  = item;
               g_in     = ground;
               k_in     = 2'd0;
               pass_in  = 1'b0;
               state_in = S_LMUL;
            end
         end
         S_LMUL: state_in = S_LACC;
         S_LACC: begin
            // Product shifted right with rounding toward minus infinity.
            case (k_ff)
               2'd0:    h0_in = prev + LAYER_W'(prod_ff >>> 16);
               2'd1:    h1_in = prev + LAYER_W'(prod_ff >>> 16);
               default: h2_in = prev + LAYER_W'(prod_ff >>> 16);
            endcase
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = pass_ff ? S_OUT : S_DCHK;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_LMUL;
            end
         end
         S_DCHK: begin
            if (den == '0) begin
               sh0_in = '0; sh1_in = '0; sh2_in = '0;
               state_in = S_FMUL;
            end else begin
               state_in = S_DGO;
            end
         end
         S_DGO: state_in = S_DWAIT;
         S_DWAIT: begin
            if (div_done) begin
               case (k_ff)
                  2'd0:    sh0_in = new_sh;
                  2'd1:    sh1_in = new_sh;
                  default: sh2_in = new_sh;
               endcase
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = S_FMUL;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_DGO;
               end
            end
         end
         S_FMUL: state_in = S_FACC;
         S_FACC: begin
            fac_in   = FAC_W'(prod_ff) - signed'({3'b0, cfg.boiler_energy});
            k_in     = 2'd0;
            state_in = S_PLO;
         end
         S_PLO: state_in = S_PHI;
         S_PHI: begin
            acc_in   = DIV_NW'(prod_ff);
            state_in = S_PSUM;
         end
         S_PSUM: begin
            acc_in   = DIV_NW'(prod_ff <<< 16) + acc_ff;
            state_in = S_VGO;
         end
         S_VGO, S_VWAIT: begin
            // A layer with zero volume takes no drop and skips the divider.
            if ((state_ff == S_VGO && vol == 16'd0) || (state_ff == S_VWAIT && div_done)) begin
               case (k_ff)
                  2'd0:    st0_in = new_st;
                  2'd1:    st1_in = new_st;
                  default: st2_in = new_st;
               endcase
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  pass_in  = 1'b1;
                  state_in = S_LMUL;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_PLO;
               end
            end else if (state_ff == S_VGO) begin
               state_in = S_VWAIT;
            end
         end
         S_OUT: begin
            if (ack) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= 2'd0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         pass_ff  <= pass_in;
      end
      item_ff <= item_in;
      g_ff    <= g_in;
      h0_ff <= h0_in; h1_ff <= h1_in; h2_ff <= h2_in;
      st0_ff <= st0_in; st1_ff <= st1_in; st2_ff <= st2_in;
      sh0_ff <= sh0_in; sh1_ff <= sh1_in; sh2_ff <= sh2_in;
      fac_ff  <= fac_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Round half up, then saturate to one byte.
   assign v = (LAYER_W+1)'(h2_ff) + (LAYER_W+1)'(32768);
   assign delivery = v[LAYER_W] ? 8'd0 :
                     (v[LAYER_W-1:24] != '0) ? 8'd255 : v[23:16];

   always_comb begin
      case (item_ff.mode)
         MODE_OFF: target = OFF_TARGET;
         MODE_ON:  target = req;
         default:  target = item_ff.call_temp;
      endcase
   end

   assign hyst_on = (target > TEMP_W'(MIN_FLOW)) && item_ff.was_heating &&
                    !item_ff.back_boiler_on;
   assign limit   = {1'b0, target} + (hyst_on ? 9'(HYSTERESIS) : 9'd0);

   assign status.idle          = (state_ff == S_IDLE);
   assign status.done          = (state_ff == S_OUT);
   assign status.delivery_temp = delivery;
   assign status.need_heat     = ({1'b0, delivery} < limit);

endmodule

FILE: hw/rtl/thermal_store_hot_water_demand.sv
// Top level of the hot-water demand block: ports, registers, ground minimum.
//
// One transfer on req is one control tick and yields one transfer on rsp.
// A tick runs six divisions on the bit-serial divider, three for the shares
// and three for the drops, and the two passes of the three-layer chain, the
// draw products and the bookkeeping on the shared multiplier. A zero spread
// skips the three share divisions, and each layer with zero volume skips its
// division. A full output register holds the core until rsp takes the
// previous result. req_tready is high only while no tick is in work; a
// finished result may wait in the output register meanwhile. Registers are
// written through csr_we, csr_index and csr_wdata; the user must write them
// only while idle, since the block itself does not enforce it.
module thermal_store_hot_water_demand import tshw_pkg::*; #(
   parameter int MIN_FLOW   = MIN_FLOW_DEF,
   parameter int HYSTERESIS = HYSTERESIS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // call_temp, next_temp, ground_temp, top_temp, mid_temp, bottom_temp,
   // mode, was_heating, back_boiler_on, cold_water_flowing
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // delivery_temp, need_heat
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   logic [7:0]      lowest_ff, lowest_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [8:0]      rsp_data_ff, rsp_data_in;
   logic            accept, ack;
   item_type        item;
   logic [6:0]      ground;
   core_status_type status;

   assign item.call_temp      = req_tdata[6:0];
   assign item.next_temp      = req_tdata[13:7];
   assign ground              = req_tdata[20:14];
   assign item.top_temp       = req_tdata[27:21];
   assign item.mid_temp       = req_tdata[34:28];
   assign item.bottom_temp    = req_tdata[41:35];
   assign item.mode           = req_tdata[43:42];
   assign item.was_heating    = req_tdata[44];
   assign item.back_boiler_on = req_tdata[45];

   assign req_tready = status.idle;
   assign accept     = req_tvalid && status.idle;
   assign ack        = status.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      lowest_in = lowest_ff;
      if (accept && (req_tdata[46] || lowest_ff > {1'b0, ground})) begin
         lowest_in = {1'b0, ground};
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BOTTOM_CAP: cfg_in.bottom_capacity = csr_wdata[15:0];
            REG_MIDDLE_CAP: cfg_in.middle_capacity = csr_wdata[15:0];
            REG_UPPER_CAP:  cfg_in.upper_capacity  = csr_wdata[15:0];
            REG_BOTTOM_VOL: cfg_in.bottom_volume   = csr_wdata[15:0];
            REG_MIDDLE_VOL: cfg_in.middle_volume   = csr_wdata[15:0];
            REG_UPPER_VOL:  cfg_in.upper_volume    = csr_wdata[15:0];
            REG_DRAW_GAIN:  cfg_in.draw_gain       = csr_wdata[15:0];
            REG_BOILER:     cfg_in.boiler_energy   = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {status.need_heat, status.delivery_temp};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bottom_capacity <= 16'd32768;
         cfg_ff.middle_capacity <= 16'd32768;
         cfg_ff.upper_capacity  <= 16'd32768;
         cfg_ff.bottom_volume   <= 16'd25600;
         cfg_ff.middle_volume   <= 16'd25600;
         cfg_ff.upper_volume    <= 16'd25600;
         cfg_ff.draw_gain       <= 16'd3072;
         cfg_ff.boiler_energy   <= 24'd11008;
         lowest_ff    <= 8'd255;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         lowest_ff    <= lowest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   tshw_core #(
      .MIN_FLOW   (MIN_FLOW),
      .HYSTERESIS (HYSTERESIS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .item   (item),
      .ground (lowest_in),
      .cfg    (cfg_ff),
      .ack    (ack),
      .status (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

endmodule

FILE: tb/sv/thermal_store_hot_water_demand_tb.sv
// Self-checking testbench of the hot-water demand block with its own predictor.
`timescale 1ns / 100ps

module thermal_store_hot_water_demand_tb import tshw_pkg::*;;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 450;
   localparam longint STORE_LIMIT = 64'sd1 << 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_BOTTOM_CAP;
   logic [23:0] csr_wdata = '0;

   typedef struct packed {
      logic [7:0] delivery_temp;
      logic       need_heat;
   } demand_type;

   demand_type  demand_queue[$];
   longint      store_reg[8];
   logic [7:0]  ground_min;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   thermal_store_hot_water_demand i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint cap_product(longint x, longint c);
      return (x * c) >>> 16;
   endfunction

   function automatic void layer_chain(input longint g, b, m, t, output longint h[3]);
      h[0] = g + cap_product(b - g, store_reg[REG_BOTTOM_CAP]);
      h[1] = h[0] + cap_product(m - h[0], store_reg[REG_MIDDLE_CAP]);
      h[2] = h[1] + cap_product(t - h[1], store_reg[REG_UPPER_CAP]);
   endfunction

   // Works out the delivered temperature and demand flag of one tick.
   function automatic demand_type predict_demand(logic [47:0] d);
      longint g, req, target, den, factor, v, num, vol, drop;
      longint h[3], rd[3], sh[3], st[3];
      int hyst;
      demand_type res;
      if (d[46] || ground_min > {1'b0, d[20:14]})
         ground_min = {1'b0, d[20:14]};
      g = longint'(ground_min) * 65536;
      req = (d[13:7] > d[6:0]) ? d[13:7] : d[6:0];
      if (d[43:42] == MODE_OFF)
         target = OFF_TARGET;
      else if (d[43:42] == MODE_ON)
         target = req;
      else
         target = d[6:0];
      rd[0] = longint'(d[41:35]) * 65536;
      rd[1] = longint'(d[34:28]) * 65536;
      rd[2] = longint'(d[27:21]) * 65536;
      layer_chain(g, rd[0], rd[1], rd[2], h);
      den = h[2] - g;
      for (int i = 0; i < 3; i++) begin
         num = h[i] - (i == 0 ? g : h[i-1]);
         if (den == 0)
            sh[i] = 0;
         else begin
            sh[i] = (num * 65536) / den;
            if (sh[i] > 64'sd2147483647) sh[i] = 64'sd2147483647;
            if (sh[i] < -64'sd2147483648) sh[i] = -64'sd2147483648;
         end
      end
      factor = (req - longint'(ground_min)) * store_reg[REG_DRAW_GAIN] - store_reg[REG_BOILER];
      for (int i = 0; i < 3; i++) begin
         vol = store_reg[REG_BOTTOM_VOL + i];
         drop = (vol == 0) ? 0 : (factor * sh[i]) / vol;
         st[i] = rd[i] - drop;
         if (st[i] > STORE_LIMIT) st[i] = STORE_LIMIT;
         if (st[i] < -STORE_LIMIT) st[i] = -STORE_LIMIT;
      end
      layer_chain(g, st[0], st[1], st[2], h);
      v = h[2] + 32768;
      if (v < 0)
         res.delivery_temp = 8'd0;
      else if ((v >>> 16) > 255)
         res.delivery_temp = 8'd255;
      else
         res.delivery_temp = v[23:16];
      hyst = (target > MIN_FLOW_DEF && d[44] && !d[45]) ? HYSTERESIS_DEF : 0;
      res.need_heat = longint'(res.delivery_temp) < target + hyst;
      return res;
   endfunction

   function automatic logic [47:0] pack_tick(int call, nxt, ground, top, mid, bot,
                                             int mode, heating, bb, flowing);
      return {1'b0, flowing[0], bb[0], heating[0], mode[1:0], bot[6:0], mid[6:0],
              top[6:0], ground[6:0], nxt[6:0], call[6:0]};
   endfunction

   function automatic logic [47:0] random_tick();
      logic [63:0] r;
      logic [47:0] d;
      r = {$urandom, $urandom};
      d = r[47:0];
      d[47] = 1'b0;
      // Keep the cold flow rare so that the ground minimum builds up.
      d[46] = ($urandom_range(3) == 0);
      return d;
   endfunction

   task automatic send_tick(logic [47:0] d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      demand_queue.push_back(predict_demand(d));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (demand_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(longint values[8]);
      wait_drained();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= values[i][23:0];
         store_reg[i] = values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_config();
      longint c[8];
      for (int i = 0; i < 3; i++) c[i] = $urandom_range(65535);
      for (int i = 3; i < 6; i++) c[i] = $urandom_range(65535, 256);
      c[REG_DRAW_GAIN] = $urandom_range(65535);
      c[REG_BOILER] = ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                               : $urandom_range(65535);
      write_config(c);
   endtask

   // Field extremes, each mode and the hysteresis conditions at reset settings.
   task automatic test_directed_ticks();
      send_tick(pack_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_tick(pack_tick(127, 127, 127, 127, 127, 127, 3, 1, 1, 1));
      send_tick(pack_tick(60, 40, 10, 70, 50, 20, 0, 1, 0, 1));
      send_tick(pack_tick(60, 40, 20, 70, 50, 20, 1, 1, 0, 0));
      send_tick(pack_tick(60, 40, 5, 70, 50, 20, 2, 1, 0, 0));
      send_tick(pack_tick(40, 65, 30, 70, 50, 20, 3, 1, 1, 0));
      send_tick(pack_tick(30, 30, 30, 30, 30, 30, 1, 1, 0, 1));
      send_tick(pack_tick(31, 0, 15, 35, 33, 31, 2, 1, 0, 1));
      send_tick(pack_tick(31, 0, 15, 35, 33, 31, 2, 0, 0, 1));
      send_tick(pack_tick(85, 120, 10, 127, 0, 127, 1, 1, 0, 1));
      send_tick(pack_tick(10, 10, 90, 0, 127, 0, 2, 0, 1, 0));
   endtask

   // Register extremes: zero spread, zero volume and saturated stores.
   task automatic test_config_extremes();
      longint cfg_min[8]  = '{0, 0, 0, 256, 256, 256, 0, 0};
      longint cfg_max[8]  = '{65535, 65535, 65535, 65535, 65535, 65535, 65535, 24'hFFFFFF};
      longint cfg_sat[8]  = '{1, 65535, 1, 256, 256, 256, 0, 24'hFFFFFF};
      longint cfg_zero[8] = '{40000, 20000, 50000, 0, 0, 0, 65535, 0};
      write_config(cfg_min);
      send_tick(pack_tick(50, 60, 20, 80, 60, 40, 1, 1, 0, 1));
      send_tick(pack_tick(127, 0, 127, 0, 0, 0, 2, 1, 0, 1));
      write_config(cfg_max);
      send_tick(pack_tick(127, 127, 0, 127, 127, 127, 1, 1, 0, 1));
      send_tick(pack_tick(5, 90, 3, 0, 127, 64, 2, 0, 0, 0));
      write_config(cfg_sat);
      send_tick(pack_tick(0, 0, 0, 127, 1, 0, 0, 0, 0, 1));
      send_tick(pack_tick(127, 127, 126, 0, 127, 127, 1, 1, 0, 1));
      send_tick(pack_tick(80, 60, 0, 127, 127, 1, 2, 1, 0, 1));
      write_config(cfg_zero);
      send_tick(pack_tick(90, 20, 10, 100, 80, 40, 1, 1, 0, 1));
      send_tick(pack_tick(50, 55, 12, 60, 60, 60, 0, 1, 1, 0));
   endtask

   task automatic test_random_ticks(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(199) == 0) wait_drained();
         send_tick(random_tick());
      end
   endtask

   always @(posedge clock) begin
      demand_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (demand_queue.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result transfer %h", rsp_tdata);
            mismatches++;
         end else begin
            want = demand_queue.pop_front();
            if (rsp_tdata[7:0] !== want.delivery_temp || rsp_tdata[8] !== want.need_heat ||
                rsp_tdata[15:9] !== '0) begin
               if (mismatches < 10)
                  $display("mismatch: expected delivery %0d need %0d, got delivery %0d need %0d",
                           want.delivery_temp, want.need_heat, rsp_tdata[7:0], rsp_tdata[8]);
               mismatches++;
            end
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      store_reg = '{32768, 32768, 32768, 25600, 25600, 25600, 3072, 11008};
      ground_min = 8'd255;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 27;
      recv_idle_pct = 75;
      test_directed_ticks();
      test_config_extremes();
      for (int blk = 0; blk < 6; blk++) begin
         if (blk == 2) begin
            send_idle_pct = 75;
            recv_idle_pct = 27;
         end else if (blk == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_config();
         test_random_ticks(280);
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && demand_queue.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
